FILE: rtl/frame_of_reference_packer_top_macros.svh
// Assertion helpers for the frame-of-reference packer.
`ifndef FRAME_OF_REFERENCE_PACKER_TOP_MACROS_SVH
`define FRAME_OF_REFERENCE_PACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FORP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FORP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/forp_pkg.sv
`timescale 1ns / 1ps

package forp_pkg;

    // Block geometry.
    localparam int MAX_BLOCK   = 32;
    localparam int STORE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Field widths.
    localparam int BYTE_BITS  = 8;
    localparam int WORD_BITS  = 4 * BYTE_BITS;
    localparam int VALUE_W    = 32;
    localparam int BW_W       = 6;
    localparam int VB_W       = 3;
    localparam int ACC_W      = 2 * WORD_BITS;
    localparam int ACC_BITS_W = 6;

    // Output stream payload layout, lowest bit first.
    localparam int MIN_LSB    = 0;
    localparam int BW_LSB     = MIN_LSB + VALUE_W;
    localparam int WORD_LSB   = BW_LSB + BW_W;
    localparam int VB_LSB     = WORD_LSB + WORD_BITS;
    localparam int OVF_LSB    = VB_LSB + VB_W;
    localparam int FIELDS_W   = OVF_LSB + 1;
    localparam int TDATA_W    = ((FIELDS_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CALC,
        ST_WIDTH,
        ST_HEADER,
        ST_READ,
        ST_APPEND,
        ST_CHECK,
        ST_TAIL
    } t_state;

    // Operations of the packing unit.
    typedef enum logic [1:0] {
        PK_IDLE,
        PK_CLEAR,
        PK_APPEND,
        PK_TAKE
    } t_pack_op;

    typedef struct packed {
        t_pack_op             op;
        logic [BW_W-1:0]      bw;
        logic [VALUE_W-1:0]   mn;
    } t_pack_ctrl;

    typedef struct packed {
        logic [ACC_BITS_W-1:0] bits;
        logic [WORD_BITS-1:0]  full_word;
        logic [WORD_BITS-1:0]  tail_word;
        logic [VB_W-1:0]       tail_bytes;
    } t_pack_stat;

endpackage

FILE: rtl/forp_store.sv
`timescale 1ns / 1ps

module forp_store
    import forp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [VALUE_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [STORE_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/forp_pack_unit.sv
`timescale 1ns / 1ps

module forp_pack_unit
    import forp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pack_ctrl         i_ctrl,
    input  logic [VALUE_W-1:0] i_value,
    output t_pack_stat         o_stat
);

    logic [ACC_W-1:0]      r_acc;
    logic [ACC_W-1:0]      n_acc;
    logic [ACC_BITS_W-1:0] r_bits;
    logic [ACC_BITS_W-1:0] n_bits;
    logic [VALUE_W-1:0]    w_adj;
    logic [ACC_BITS_W-1:0] w_full_sh;
    logic [ACC_BITS_W-1:0] w_tail_sh;
    logic [ACC_BITS_W:0]   w_tail_round;

    // Zeros stay zero; every other value is taken relative to the minimum.
    assign w_adj = (i_value != '0) ? (i_value - i_ctrl.mn) : '0;

    // Accumulator update: new bits always enter at the bottom.
    always_comb begin
        n_acc  = r_acc;
        n_bits = r_bits;
        case (i_ctrl.op)
            PK_CLEAR: begin
                n_acc  = '0;
                n_bits = '0;
            end
            PK_APPEND: begin
                n_acc  = (r_acc << i_ctrl.bw) | {{(ACC_W-VALUE_W){1'b0}}, w_adj};
                n_bits = r_bits + ACC_BITS_W'(i_ctrl.bw);
            end
            PK_TAKE: begin
                n_bits = r_bits - ACC_BITS_W'(WORD_BITS);
            end
            default: begin
                n_acc  = r_acc;
                n_bits = r_bits;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_bits <= '0;
        end else begin
            r_acc  <= n_acc;
            r_bits <= n_bits;
        end
    end

    // The oldest pending bits sit just below bit r_bits; anything above is stale.
    assign w_full_sh    = r_bits - ACC_BITS_W'(WORD_BITS);
    assign w_tail_sh    = ACC_BITS_W'(WORD_BITS) - r_bits;
    assign w_tail_round = {1'b0, r_bits} + (ACC_BITS_W+1)'(BYTE_BITS - 1);

    assign o_stat.bits       = r_bits;
    assign o_stat.full_word  = WORD_BITS'(r_acc >> w_full_sh);
    assign o_stat.tail_word  = WORD_BITS'(r_acc << w_tail_sh);
    assign o_stat.tail_bytes = VB_W'(w_tail_round >> $clog2(BYTE_BITS));

endmodule

FILE: rtl/frame_of_reference_packer_top.sv
`timescale 1ns / 1ps

// Frame-of-reference packer. Values of a block stream in one per cycle on the
// slave side, the last one marked by tlast; up to MAX_BLOCK are kept and the
// rest dropped, which sets the overflow flag of the header. The minimum nonzero
// value and the maximum are tracked while loading. After the last value the
// block stops taking input and forms the range in ST_CALC. A shift loop then
// finds the bit width in ST_WIDTH by shifting the range right until it is zero.
// It sends the header, then, if the width is nonzero, walks the value memory
// once: a read, an append to the packing accumulator and a check for each
// stored value, and a partial last word is sent from ST_TAIL. A wait on the
// master side holds back the header, each full word and the partial word. The
// packed words leave MSB first, tlast marks the final result of the block, and
// input is taken again once the last result is queued.
`include "frame_of_reference_packer_top_macros.svh"

module frame_of_reference_packer_top
    import forp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Slave side.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic               s_axis_tlast,  // last
    // Master side.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [31:0] minimum_value, [37:32] bit_width, [69:38] packed_word,
    // [72:70] valid_bytes, [73] overflow, [79:74] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,  // is_header
    output logic               m_axis_tlast   // end_of_run
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [VALUE_W-1:0] r_min, n_min;
    logic [VALUE_W-1:0] r_max, n_max;
    logic               r_seen, n_seen;
    logic               r_ovf, n_ovf;
    logic [VALUE_W-1:0] r_scan, n_scan;
    logic [BW_W-1:0]    r_width, n_width;
    logic [CNT_W-1:0]   r_idx, n_idx;

    logic               r_out_valid, n_out_valid;
    logic [TDATA_W-1:0] r_out_data, n_out_data;
    logic               r_out_user, n_out_user;
    logic               r_out_last, n_out_last;

    logic               w_in_req;
    logic               w_slot_free;
    logic               w_wr_en;
    logic [VALUE_W-1:0] w_rd_data;
    t_pack_ctrl         w_pack_ctrl;
    t_pack_stat         w_pack_stat;
    logic               w_idx_end;

    logic               w_hdr_out;
    logic               w_word_out;
    logic               w_full_out;
    logic [BW_W-1:0]    w_out_bw;
    logic [VB_W-1:0]    w_out_vb;
    logic [VALUE_W-1:0] w_out_min;
    logic               w_take;

    // Value memory.
    forp_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Packing accumulator.
    forp_pack_unit u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_pack_ctrl),
        .i_value (w_rd_data),
        .o_stat  (w_pack_stat)
    );

    assign s_axis_tready = (r_state == ST_LOAD);
    assign w_in_req      = s_axis_tvalid && s_axis_tready;
    assign w_wr_en       = w_in_req && (r_count < CNT_W'(MAX_BLOCK));
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_idx_end     = (r_idx == r_count);

    // Sequencer: next state, block bookkeeping and the output register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_seen      = r_seen;
        n_ovf       = r_ovf;
        n_scan      = r_scan;
        n_width     = r_width;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        w_pack_ctrl.op = PK_IDLE;
        w_pack_ctrl.bw = r_width;
        w_pack_ctrl.mn = r_min;

        case (r_state)
            ST_LOAD: begin
                if (w_in_req) begin
                    if (w_wr_en) begin
                        n_count = r_count + 1'b1;
                        if (s_axis_tdata != '0) begin
                            n_seen = 1'b1;
                            if (s_axis_tdata < r_min) begin
                                n_min = s_axis_tdata;
                            end
                        end
                        if (s_axis_tdata > r_max) begin
                            n_max = s_axis_tdata;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                // Frame of reference and the range left to encode.
                n_min   = r_seen ? r_min : '0;
                n_scan  = r_seen ? (r_max - r_min) : '0;
                n_width = '0;
                n_state = ST_WIDTH;
            end
            ST_WIDTH: begin
                // Bit length of the range, one bit per cycle.
                if (r_scan != '0) begin
                    n_scan  = r_scan >> 1;
                    n_width = r_width + 1'b1;
                end else begin
                    n_state = ST_HEADER;
                end
            end
            ST_HEADER: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = 1'b1;
                    n_out_last  = (r_width == '0);
                    n_out_data  = '0;
                    n_out_data[MIN_LSB +: VALUE_W] = r_min;
                    n_out_data[BW_LSB +: BW_W]     = r_width;
                    n_out_data[OVF_LSB]            = r_ovf;
                    if (r_width == '0) begin
                        n_state = ST_LOAD;
                    end else begin
                        w_pack_ctrl.op = PK_CLEAR;
                        n_idx   = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // Memory address is presented; data arrives next cycle.
                n_state = ST_APPEND;
            end
            ST_APPEND: begin
                w_pack_ctrl.op = PK_APPEND;
                n_idx   = r_idx + 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_pack_stat.bits >= ACC_BITS_W'(WORD_BITS)) begin
                    if (w_slot_free) begin
                        w_pack_ctrl.op = PK_TAKE;
                        n_out_valid = 1'b1;
                        n_out_user  = 1'b0;
                        n_out_last  = w_idx_end &&
                                      (w_pack_stat.bits == ACC_BITS_W'(WORD_BITS));
                        n_out_data  = '0;
                        n_out_data[WORD_LSB +: WORD_BITS] = w_pack_stat.full_word;
                        n_out_data[VB_LSB +: VB_W]        = VB_W'(WORD_BITS / BYTE_BITS);
                        if (!w_idx_end) begin
                            n_state = ST_READ;
                        end else if (w_pack_stat.bits != ACC_BITS_W'(WORD_BITS)) begin
                            n_state = ST_TAIL;
                        end else begin
                            n_state = ST_LOAD;
                        end
                    end
                end else if (!w_idx_end) begin
                    n_state = ST_READ;
                end else if (w_pack_stat.bits != '0) begin
                    n_state = ST_TAIL;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_TAIL: begin
                // Partial final word, padded with zeros below the packed bits.
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_data  = '0;
                    n_out_data[WORD_LSB +: WORD_BITS] = w_pack_stat.tail_word;
                    n_out_data[VB_LSB +: VB_W]        = w_pack_stat.tail_bytes;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // Block bookkeeping returns to its start values once the block is done.
        if (r_state != ST_LOAD && n_state == ST_LOAD) begin
            n_count = '0;
            n_min   = '1;
            n_max   = '0;
            n_seen  = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_seen      <= n_seen;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_width    <= n_width;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    // Views of the output register for the checks below.
    assign w_hdr_out  = m_axis_tvalid && m_axis_tuser;
    assign w_word_out = m_axis_tvalid && !m_axis_tuser;
    assign w_out_bw   = m_axis_tdata[BW_LSB +: BW_W];
    assign w_out_vb   = m_axis_tdata[VB_LSB +: VB_W];
    assign w_out_min  = m_axis_tdata[MIN_LSB +: VALUE_W];
    assign w_full_out = w_word_out && (w_out_vb == VB_W'(WORD_BITS / BYTE_BITS));
    assign w_take     = (r_state == ST_CHECK) && (w_pack_ctrl.op == PK_TAKE);

    // Checks.
    `FORP_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_BLOCK), "count past limit")
    `FORP_ASSERT_SAME(a_zero_width_ends, w_hdr_out && (w_out_bw == '0), m_axis_tlast, "header not last")
    `FORP_ASSERT_SAME(a_word_bytes, w_word_out, (w_out_vb != '0) && (w_out_min == '0), "bad data word")
    `FORP_ASSERT_NEXT(a_take_full, w_take, w_full_out, "full word not presented after take")

endmodule

FILE: verif/frame_of_reference_packer_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the frame-of-reference packer. It watches both stream
// channels, keeps its own copy of the block state, works out the header and
// packed words that each closing value must produce, and compares every
// result request on the master side with the oldest prediction, field by field.
module frame_of_reference_packer_checker
    import forp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic               s_axis_tlast,  // last
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [31:0] minimum_value, [37:32] bit_width, [69:38] packed_word,
    // [72:70] valid_bytes, [73] overflow, [79:74] zero
    input  logic [TDATA_W-1:0] m_axis_tdata,
    input  logic               m_axis_tuser,  // is_header
    input  logic               m_axis_tlast,  // end_of_run
    output int                 o_fail_count,
    output int                 o_pending_count
);

    typedef struct packed {
        logic                 is_header;
        logic [VALUE_W-1:0]   minimum_value;
        logic [BW_W-1:0]      bit_width;
        logic [WORD_BITS-1:0] packed_word;
        logic [VB_W-1:0]      valid_bytes;
        logic                 overflow;
        logic                 end_of_run;
    } t_result;

    // Block state as the packer should hold it.
    logic [VALUE_W-1:0] held_values [STORE_DEPTH];
    int                 held_count;
    logic [VALUE_W-1:0] min_nonzero;
    logic [VALUE_W-1:0] max_value;
    logic               any_nonzero;
    logic               dropped_any;

    // Results predicted but not yet seen on the master side.
    t_result            queued_outputs [$];
    t_result            oldest;

    // Binary length of a value, 0 for zero.
    function automatic int significant_bits(input logic [VALUE_W-1:0] x);
        int n;
        n = 0;
        while (x != '0) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    task automatic clear_block();
        held_count  = 0;
        min_nonzero = '1;
        max_value   = '0;
        any_nonzero = 1'b0;
        dropped_any = 1'b0;
    endtask

    task automatic queue_result(input logic                 hdr,
                                input logic [VALUE_W-1:0]   mn,
                                input logic [BW_W-1:0]      bw,
                                input logic [WORD_BITS-1:0] word,
                                input logic [VB_W-1:0]      vb,
                                input logic                 ovf,
                                input logic                 eor);
        t_result r;
        r.is_header     = hdr;
        r.minimum_value = mn;
        r.bit_width     = bw;
        r.packed_word   = word;
        r.valid_bytes   = vb;
        r.overflow      = ovf;
        r.end_of_run    = eor;
        queued_outputs.insert(queued_outputs.size(), r);
    endtask

    // Take one accepted value; on the closing value predict the header and
    // the packed words of the whole block.
    task automatic absorb_value(input logic [VALUE_W-1:0] v, input logic is_last);
        logic [VALUE_W-1:0]     mn;
        logic [VALUE_W-1:0]     adj;
        logic [2*WORD_BITS-1:0] acc;
        int                     width;
        int                     total_bits;
        int                     bytes_left;
        int                     words;
        int                     acc_bits;
        int                     n;
        int                     vb;

        // Values beyond the block capacity are dropped, the last one too.
        if (held_count < MAX_BLOCK && held_count < STORE_DEPTH) begin
            held_values[ADDR_W'(held_count)] = v;
            held_count++;
            if (v != '0) begin
                any_nonzero = 1'b1;
                if (v < min_nonzero)
                    min_nonzero = v;
            end
            if (v > max_value)
                max_value = v;
        end else begin
            dropped_any = 1'b1;
        end

        if (!is_last)
            return;

        mn         = any_nonzero ? min_nonzero : '0;
        width      = significant_bits(any_nonzero ? max_value - mn : '0);
        total_bits = held_count * width;
        words      = (total_bits + WORD_BITS - 1) / WORD_BITS;
        queue_result(1'b1, mn, BW_W'(width), '0, '0, dropped_any, words == 0);

        // Pack MSB first; whole words leave as soon as they fill up.
        n          = 1;
        bytes_left = (total_bits + BYTE_BITS - 1) / BYTE_BITS;
        acc        = '0;
        acc_bits   = 0;
        if (width != 0) begin
            for (int i = 0; i < held_count; i++) begin
                adj = held_values[ADDR_W'(i)];
                if (adj != '0)
                    adj = adj - mn;
                acc      = (acc << width) | adj;
                acc_bits += width;
                while (acc_bits >= WORD_BITS) begin
                    vb         = (bytes_left > 4) ? 4 : bytes_left;
                    acc_bits   -= WORD_BITS;
                    bytes_left -= vb;
                    queue_result(1'b0, '0, '0, WORD_BITS'(acc >> acc_bits), VB_W'(vb),
                                 1'b0, n == words);
                    n++;
                    if (acc_bits == 0)
                        acc = '0;
                    else
                        acc &= (64'd1 << acc_bits) - 64'd1;
                end
            end
            // A partial word is padded with zeros at the low end.
            if (acc_bits > 0)
                queue_result(1'b0, '0, '0, WORD_BITS'(acc << (WORD_BITS - acc_bits)),
                             VB_W'((acc_bits + BYTE_BITS - 1) / BYTE_BITS), 1'b0, 1'b1);
        end

        clear_block();
    endtask

    task automatic check_field(input string name,
                               input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    // Inputs are taken before outputs so that a prediction made at an edge is
    // always in place before anything can be compared against it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_block();
            for (int i = 0; i < STORE_DEPTH; i++)
                held_values[ADDR_W'(i)] = '0;
            queued_outputs.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_value(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (queued_outputs.size() == 0) begin
                    $error("result request with no result predicted: tdata 0x%0h",
                           m_axis_tdata);
                    o_fail_count++;
                end else begin
                    oldest = queued_outputs.pop_front();
                    check_field("is_header", VALUE_W'(oldest.is_header),
                                VALUE_W'(m_axis_tuser));
                    check_field("minimum_value", oldest.minimum_value,
                                m_axis_tdata[MIN_LSB +: VALUE_W]);
                    check_field("bit_width", VALUE_W'(oldest.bit_width),
                                VALUE_W'(m_axis_tdata[BW_LSB +: BW_W]));
                    check_field("packed_word", oldest.packed_word,
                                m_axis_tdata[WORD_LSB +: WORD_BITS]);
                    check_field("valid_bytes", VALUE_W'(oldest.valid_bytes),
                                VALUE_W'(m_axis_tdata[VB_LSB +: VB_W]));
                    check_field("overflow", VALUE_W'(oldest.overflow),
                                VALUE_W'(m_axis_tdata[OVF_LSB]));
                    check_field("end_of_run", VALUE_W'(oldest.end_of_run),
                                VALUE_W'(m_axis_tlast));
                end
            end
        end
        o_pending_count = queued_outputs.size();
    end

endmodule

FILE: verif/tb_frame_of_reference_packer_top.sv
`timescale 1ns / 1ps

// Drives blocks of values into the frame-of-reference packer and lets the
// checker beside it predict and compare the header and packed words. A short
// directed set of blocks comes first, then random blocks of mixed length and
// spread, with random gaps on both channels and one long stall on the master
// side that backs the packer up onto its input.
module tb_frame_of_reference_packer_top
    import forp_pkg::*;
();

    typedef enum {
        MIX_FULL,
        MIX_NARROW,
        MIX_SPARSE,
        MIX_ZERO,
        MIX_SAME
    } t_value_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata;   // [31:0] value
    logic               s_axis_tlast;   // last
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // minimum, width, word, bytes, overflow
    logic               m_axis_tuser;   // is_header
    logic               m_axis_tlast;   // end_of_run

    int                 fail_count;
    int                 pending_count;
    int                 sent_count;

    frame_of_reference_packer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    frame_of_reference_packer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // One value request; starts and ends at a falling edge. Random gaps come
    // first, except in the burst window where the sender never pauses.
    task automatic send_value(input logic [VALUE_W-1:0] v, input logic is_last);
        while (!(sent_count >= 150 && sent_count < 250) && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= is_last;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sent_count++;
        @(negedge i_clk);
    endtask

    // A block of len values drawn according to mix, the last one marked.
    task automatic send_block(input int len, input t_value_mix mix);
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] v;
        int                 w;
        base = $urandom;
        w    = $urandom_range(0, 32);
        mask = (w == 32) ? '1 : ((32'd1 << w) - 32'd1);
        for (int i = 0; i < len; i++) begin
            case (mix)
                MIX_FULL:   v = $urandom;
                MIX_NARROW: v = base + ($urandom & mask);
                MIX_SPARSE: v = ($urandom_range(99) < 40) ? '0 : base + ($urandom & mask);
                MIX_ZERO:   v = '0;
                default:    v = base;
            endcase
            send_value(v, i == len - 1);
        end
    endtask

    // Reset, directed blocks, random blocks, drain and verdict.
    initial begin
        int         random_start;
        int         len;
        int         pick;
        t_value_mix mix;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        sent_count    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A lone zero: minimum and width are zero and the header ends the run.
        send_value(32'd0, 1'b1);
        // A leading zero must not pull the minimum down to zero.
        send_value(32'd0, 1'b0);
        send_value(32'd5, 1'b0);
        send_value(32'd7, 1'b1);
        // Full 32-bit width, two whole words.
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'd1, 1'b1);
        // Equal nonzero values give a zero width and no data words.
        send_value(32'd123, 1'b1);
        send_value(32'd9, 1'b0);
        send_value(32'd9, 1'b0);
        send_value(32'd9, 1'b1);
        // Zeros around a single nonzero value still pack nothing.
        send_value(32'd0, 1'b0);
        send_value(32'd0, 1'b0);
        send_value(32'd1, 1'b0);
        send_value(32'd0, 1'b1);
        // Exactly one full word at width eight.
        send_value(32'd1, 1'b0);
        send_value(32'd256, 1'b0);
        send_value(32'd2, 1'b0);
        send_value(32'd3, 1'b1);
        // The largest value as the only nonzero one.
        send_value(32'd0, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b1);
        // Three values at width 31 leave a partial final word.
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h0000_0001, 1'b1);

        // Random part, opened by a block too long for the store.
        random_start = sent_count;
        send_block(35, MIX_NARROW);
        while (sent_count - random_start < 395) begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(1, 10);
            else if (pick < 93)
                len = $urandom_range(11, 32);
            else
                len = $urandom_range(33, 38);
            pick = $urandom_range(99);
            if (pick < 30)
                mix = MIX_FULL;
            else if (pick < 70)
                mix = MIX_NARROW;
            else if (pick < 88)
                mix = MIX_SPARSE;
            else if (pick < 94)
                mix = MIX_ZERO;
            else
                mix = MIX_SAME;
            send_block(len, mix);
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every predicted result, then a quiet stretch.
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        if (fail_count == 0)
            $display("frame_of_reference_packer_top test passed");
        else
            $display("frame_of_reference_packer_top test failed");
        $finish;
    end

    // Master-side ready: random stalls, one no-stall window, and a single long
    // hold-off that lets the packer fill up while values keep coming.
    initial begin
        int   hold_left;
        logic hold_done;
        m_axis_tready = 1'b0;
        hold_left     = 0;
        hold_done     = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_count >= 100) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (sent_count >= 260 && sent_count < 340) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("frame_of_reference_packer_top test failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/forp_pkg.sv
rtl/forp_store.sv
rtl/forp_pack_unit.sv
rtl/frame_of_reference_packer_top.sv
verif/frame_of_reference_packer_checker.sv
verif/tb_frame_of_reference_packer_top.sv
